@@ src/dq_pkg.sv @@
// Shared constants, request and status codes, and state type for the deque core.
`default_nettype none
package dq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int OCC_BITS  = 5;
    localparam int REQ_BITS  = 3;
    localparam int STS_BITS  = 2;

    localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_PEEK       = 3'd4;

    localparam logic [STS_BITS-1:0] STS_DONE  = 2'd0;
    localparam logic [STS_BITS-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_BITS-1:0] STS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SEND
    } t_state;

endpackage
`default_nettype wire

@@ src/dq_req_if.sv @@
// Request channel: valid/ready handshake carrying the request code and push word.
`default_nettype none
interface dq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [dq_pkg::REQ_BITS-1:0]  req_type;
    logic signed [dq_pkg::WORD_BITS-1:0] push_word;

    modport source (output valid, req_type, push_word, input ready);
    modport sink   (input valid, req_type, push_word, output ready);
endinterface
`default_nettype wire

@@ src/dq_rsp_if.sv @@
// Result channel: valid/ready handshake carrying popped word, end words, occupancy, status.
`default_nettype none
interface dq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [dq_pkg::WORD_BITS-1:0] popped_word;
    logic signed [dq_pkg::WORD_BITS-1:0] front_word;
    logic signed [dq_pkg::WORD_BITS-1:0] back_word;
    logic        [dq_pkg::OCC_BITS-1:0]  occupancy;
    logic        [dq_pkg::STS_BITS-1:0]  status;

    modport source (output valid, popped_word, front_word, back_word, occupancy, status,
                    input ready);
    modport sink   (input valid, popped_word, front_word, back_word, occupancy, status,
                    output ready);
endinterface
`default_nettype wire

@@ src/dq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ src/double_ended_queue_core.sv @@
// Top level of the bounded double-ended queue held in a ring-buffer RAM.
//
// Usage:
//   i_req carries one request per transfer: push front, push back, pop front,
//   pop back or peek (codes above peek also act as a peek). o_rsp carries one
//   result per request: the popped word (0 for push and peek, -1 for a pop on
//   an empty deque), the front and back words after the request (-1 when
//   empty), the occupancy and a status (done, empty, full).
//   A request is transferred in S_IDLE; its result is presented in S_SEND,
//   which follows S_IDLE directly, or through S_FETCH for a pop that leaves
//   at least one word, because the new end word must be fetched from the RAM
//   (one read port, registered read data). One request is in flight at a
//   time, so the next request is taken only after the result has transferred.
//   Front and back words are cached in registers, so pushes need no RAM read.
//   Reset clears pointers and occupancy and holds i_req ready low; RAM
//   contents are never read before being written, so no clearing pass.
//   When the receiver stalls, the result is held on o_rsp and no new request
//   is taken until it transfers.
`default_nettype none
module double_ended_queue_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dq_req_if.sink     i_req,
    dq_rsp_if.source   o_rsp
);

    localparam logic [dq_pkg::PTR_BITS-1:0]  PTR_LAST = dq_pkg::PTR_BITS'(dq_pkg::DEPTH - 1);
    localparam logic [dq_pkg::OCC_BITS-1:0]  OCC_FULL = dq_pkg::OCC_BITS'(dq_pkg::DEPTH);
    localparam logic [dq_pkg::WORD_BITS-1:0] NONE_WORD = '1;

    dq_pkg::t_state r_state, n_state;

    logic [dq_pkg::PTR_BITS-1:0]  r_fp, n_fp;
    logic [dq_pkg::PTR_BITS-1:0]  r_bp, n_bp;
    logic [dq_pkg::OCC_BITS-1:0]  r_count, n_count;
    logic [dq_pkg::WORD_BITS-1:0] r_front, n_front;
    logic [dq_pkg::WORD_BITS-1:0] r_back, n_back;
    logic [dq_pkg::WORD_BITS-1:0] r_popped, n_popped;
    logic [dq_pkg::STS_BITS-1:0]  r_status, n_status;
    logic                         r_fetch_front, n_fetch_front;
    logic                         fetch;

    logic [dq_pkg::PTR_BITS-1:0]  fp_inc, fp_dec, bp_inc, bp_dec, bp_dec2;
    logic                         we;
    logic [dq_pkg::PTR_BITS-1:0]  waddr, raddr;
    logic [dq_pkg::WORD_BITS-1:0] rdata;
    logic                         accept;
    logic                         empty, full, multi;

    // Ring pointer neighbors
    assign fp_inc  = (r_fp == PTR_LAST) ? '0 : r_fp + 1'b1;
    assign fp_dec  = (r_fp == '0) ? PTR_LAST : r_fp - 1'b1;
    assign bp_inc  = (r_bp == PTR_LAST) ? '0 : r_bp + 1'b1;
    assign bp_dec  = (r_bp == '0) ? PTR_LAST : r_bp - 1'b1;
    assign bp_dec2 = (bp_dec == '0) ? PTR_LAST : bp_dec - 1'b1;

    assign accept = i_req.valid && i_req.ready;
    assign empty  = (r_count == '0);
    assign full   = (r_count >= OCC_FULL);
    assign multi  = (r_count > dq_pkg::OCC_BITS'(1));

    dq_ram #(
        .WIDTH (dq_pkg::WORD_BITS),
        .DEPTH (dq_pkg::DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.push_word),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = fetch ? dq_pkg::S_FETCH : dq_pkg::S_SEND;
                end
            end
            dq_pkg::S_FETCH: begin
                n_state = dq_pkg::S_SEND;
            end
            dq_pkg::S_SEND: begin
                if (o_rsp.ready) begin
                    n_state = dq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::S_IDLE;
            end
        endcase
    end

    // Request decode, RAM access and state update
    always_comb begin
        n_fp          = r_fp;
        n_bp          = r_bp;
        n_count       = r_count;
        n_front       = r_front;
        n_back        = r_back;
        n_popped      = r_popped;
        n_status      = r_status;
        n_fetch_front = r_fetch_front;
        fetch         = 1'b0;
        we            = 1'b0;
        waddr         = r_bp;
        raddr         = fp_inc;

        if (r_state == dq_pkg::S_FETCH) begin
            // Load the new end word read from the RAM
            if (r_fetch_front) begin
                n_front = rdata;
            end else begin
                n_back = rdata;
            end
        end else if (accept) begin
            n_popped = '0;
            n_status = dq_pkg::STS_DONE;
            case (i_req.req_type)
                dq_pkg::REQ_PUSH_FRONT: begin
                    if (full) begin
                        n_status = dq_pkg::STS_FULL;
                    end else begin
                        we      = 1'b1;
                        waddr   = fp_dec;
                        n_fp    = fp_dec;
                        n_count = r_count + 1'b1;
                        n_front = i_req.push_word;
                        if (empty) begin
                            n_back = i_req.push_word;
                        end
                    end
                end
                dq_pkg::REQ_PUSH_BACK: begin
                    if (full) begin
                        n_status = dq_pkg::STS_FULL;
                    end else begin
                        we      = 1'b1;
                        waddr   = r_bp;
                        n_bp    = bp_inc;
                        n_count = r_count + 1'b1;
                        n_back  = i_req.push_word;
                        if (empty) begin
                            n_front = i_req.push_word;
                        end
                    end
                end
                dq_pkg::REQ_POP_FRONT: begin
                    if (empty) begin
                        n_popped = NONE_WORD;
                        n_status = dq_pkg::STS_EMPTY;
                    end else begin
                        n_popped      = r_front;
                        n_fp          = fp_inc;
                        n_count       = r_count - 1'b1;
                        raddr         = fp_inc;
                        fetch         = multi;
                        n_fetch_front = 1'b1;
                    end
                end
                dq_pkg::REQ_POP_BACK: begin
                    if (empty) begin
                        n_popped = NONE_WORD;
                        n_status = dq_pkg::STS_EMPTY;
                    end else begin
                        n_popped      = r_back;
                        n_bp          = bp_dec;
                        n_count       = r_count - 1'b1;
                        raddr         = bp_dec2;
                        fetch         = multi;
                        n_fetch_front = 1'b0;
                    end
                end
                default: begin
                    // Peek: hold everything
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::S_IDLE;
            r_fp    <= '0;
            r_bp    <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_fp    <= n_fp;
            r_bp    <= n_bp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front       <= n_front;
        r_back        <= n_back;
        r_popped      <= n_popped;
        r_status      <= n_status;
        r_fetch_front <= n_fetch_front;
    end

    // Handshake and result outputs; take no request while reset is held
    assign i_req.ready       = i_rst_n && (r_state == dq_pkg::S_IDLE);
    assign o_rsp.valid       = (r_state == dq_pkg::S_SEND);
    assign o_rsp.popped_word = r_popped;
    assign o_rsp.front_word  = empty ? NONE_WORD : r_front;
    assign o_rsp.back_word   = empty ? NONE_WORD : r_back;
    assign o_rsp.occupancy   = r_count;
    assign o_rsp.status      = r_status;

endmodule
`default_nettype wire
